// ===== design/assert_macros.svh =====
// Assertion macros shared by the tester RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MCT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MCT_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MCT_ASSERT(name, clk, rst, prop, msg)
`define MCT_ASSERT_NEVER(name, clk, rst, cond, msg)
`endif
`endif

// ===== design/mct_pkg.sv =====
// Types and constants of the motor on/off cycle tester.
// No dependencies; used by all tester modules.
package mct_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_ON_SECONDS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_SECONDS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_TOTAL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEST_FREQ_HZ   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSES_PER_REV = 3'd4;

   localparam int MS_PER_S  = 1000;
   localparam int S_PER_MIN = 60;
   localparam int PCT_SCALE = 100;
   localparam int PCT_LIMIT = 20;

   // Shared divider: dividend shifted in MSB first, one quotient bit per step.
   localparam int DIV_DVD_W  = 26;
   localparam int DIV_STEP_W = $clog2(DIV_DVD_W + 1);
   localparam int MEAN_STEPS = 16;

   typedef enum logic [1:0] {
      PHASE_OFF  = 2'd0,
      PHASE_ON   = 2'd1,
      PHASE_DONE = 2'd2
   } phase_type;

   typedef enum logic {
      DIV_TARGET,
      DIV_MEAN
   } div_sel_type;

   typedef struct packed {
      logic        step;
      logic        div_start;
      div_sel_type div_sel;
      logic        latch_tgt;
      logic        latch_mean;
      logic        check;
      logic        publish;
   } cmd_type;

   typedef struct packed {
      logic record;
      logic div_busy;
      logic slot_free;
   } sts_type;

   typedef struct packed {
      logic        pwm_enable;
      logic        record_valid;
      logic [7:0]  record_cycle;
      logic [15:0] target_rpm;
      logic [15:0] peak_rpm;
      logic [15:0] mean_rpm;
      logic        speed_error;
      logic        spun_up;
      logic        test_done;
      logic [1:0]  phase_now;
   } rsp_type;

endpackage

// ===== design/mct_req_if.sv =====
// Request channel of the tester: valid/ready plus one sample transaction.
// No dependencies.
interface mct_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        run_flag;
   logic [15:0] rpm_sample;

   modport source (output valid, now_ms, run_flag, rpm_sample, input ready);
   modport sink   (input valid, now_ms, run_flag, rpm_sample, output ready);
endinterface

// ===== design/mct_rsp_if.sv =====
// Response channel of the tester: valid/ready plus one result transaction.
// No dependencies.
interface mct_rsp_if;
   logic        valid;
   logic        ready;
   logic        pwm_enable;
   logic        record_valid;
   logic [7:0]  record_cycle;
   logic [15:0] target_rpm;
   logic [15:0] peak_rpm;
   logic [15:0] mean_rpm;
   logic        speed_error;
   logic        spun_up;
   logic        test_done;
   logic [1:0]  phase_now;

   modport source (output valid, pwm_enable, record_valid, record_cycle, target_rpm,
                   peak_rpm, mean_rpm, speed_error, spun_up, test_done, phase_now,
                   input ready);
   modport sink   (input valid, pwm_enable, record_valid, record_cycle, target_rpm,
                   peak_rpm, mean_rpm, speed_error, spun_up, test_done, phase_now,
                   output ready);
endinterface

// ===== design/mct_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on mct_pkg.
module mct_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [31:0]                      rem_init,
   input  logic [mct_pkg::DIV_DVD_W-1:0]    dividend,
   input  logic [mct_pkg::DIV_STEP_W-1:0]   steps,
   input  logic [31:0]                      divisor,
   output logic                             busy,
   output logic [mct_pkg::DIV_DVD_W-1:0]    quotient
);
   import mct_pkg::*;

   logic [31:0]           rem_ff, rem_in;
   logic [DIV_DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_DVD_W-1:0]  quo_ff, quo_in;
   logic [DIV_STEP_W-1:0] steps_ff, steps_in;
   logic [32:0]           trial;
   logic                  fits;

   always_comb begin
      trial    = {rem_ff, dvd_ff[DIV_DVD_W-1]};
      fits     = trial >= {1'b0, divisor};
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      steps_in = steps_ff;
      if (start) begin
         rem_in   = rem_init;
         dvd_in   = dividend;
         quo_in   = '0;
         steps_in = steps;
      end else if (steps_ff != '0) begin
         // the remainder stays below the divisor, so 32 bits hold it
         rem_in   = fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
         dvd_in   = {dvd_ff[DIV_DVD_W-2:0], 1'b0};
         quo_in   = {quo_ff[DIV_DVD_W-2:0], fits};
         steps_in = steps_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else begin
         steps_ff <= steps_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign busy     = steps_ff != '0;
   assign quotient = quo_ff;

endmodule

// ===== design/mct_datapath.sv =====
// Tester datapath: configuration, phase state, accumulators, result staging.
// Depends on mct_pkg and mct_divider.
module mct_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [mct_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mct_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  mct_pkg::cmd_type                cmd,
   output mct_pkg::sts_type                sts,
   input  logic [31:0]                     req_now_ms,
   input  logic                            req_run_flag,
   input  logic [15:0]                     req_rpm_sample,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output mct_pkg::rsp_type                rsp_data
);
   import mct_pkg::*;

   // configuration
   logic [11:0] on_sec_ff, off_sec_ff;
   logic [7:0]  cyc_total_ff, ppr_ff;
   logic [19:0] freq_ff;

   // phase state
   phase_type   phase_ff, phase_e, nx_phase;
   logic        run_prev_ff;
   logic [7:0]  cycle_ff, cyc_e, nx_cycle;
   logic [31:0] start_ms_ff, start_e, nx_start;
   logic [15:0] peak_ff, peak_e, nx_peak;
   logic [47:0] total_ff, total_e, nx_total;
   logic [31:0] count_ff, count_e, nx_count;
   logic        rise, nx_rec, nx_done;
   logic [31:0] elapsed;
   logic [21:0] on_ms, off_ms;

   // result staging and output register
   rsp_type     res_ff, res_in;
   rsp_type     out_ff;
   logic        out_valid_ff;

   // divider
   div_sel_type                 sel_ff;
   logic [31:0]                 div_rem_init, div_divisor;
   logic [DIV_DVD_W-1:0]        div_dividend, div_quo;
   logic [DIV_STEP_W-1:0]       div_steps;
   logic                        div_busy;
   logic [15:0]                 diff;

   mct_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .rem_init (div_rem_init),
      .dividend (div_dividend),
      .steps    (div_steps),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   always_comb begin
      if (cmd.div_sel == DIV_MEAN) begin
         // the mean fits 16 bits, so the high part already sits below the count
         div_rem_init = total_ff[47:16];
         div_dividend = {total_ff[15:0], {(DIV_DVD_W-16){1'b0}}};
         div_steps    = DIV_STEP_W'(MEAN_STEPS);
      end else begin
         div_rem_init = '0;
         div_dividend = DIV_DVD_W'(freq_ff) * DIV_DVD_W'(S_PER_MIN);
         div_steps    = DIV_STEP_W'(DIV_DVD_W);
      end
      div_divisor = (sel_ff == DIV_MEAN) ? count_ff : {24'd0, ppr_ff};
   end

   // one step of the phase sequencer for the offered transaction
   always_comb begin
      rise    = req_run_flag && !run_prev_ff;
      phase_e = rise ? PHASE_ON : phase_ff;
      cyc_e   = rise ? 8'd0 : cycle_ff;
      start_e = rise ? req_now_ms : start_ms_ff;
      peak_e  = rise ? 16'd0 : peak_ff;
      total_e = rise ? 48'd0 : total_ff;
      count_e = rise ? 32'd0 : count_ff;
      on_ms   = 22'(on_sec_ff) * 22'(MS_PER_S);
      off_ms  = 22'(off_sec_ff) * 22'(MS_PER_S);
      elapsed = req_now_ms - start_e;

      nx_phase = phase_e;
      nx_cycle = cyc_e;
      nx_start = start_e;
      nx_peak  = peak_e;
      nx_total = total_e;
      nx_count = count_e;
      nx_rec   = 1'b0;
      nx_done  = 1'b0;

      if (!req_run_flag) begin
         nx_phase = PHASE_OFF;
      end else begin
         case (phase_e)
            PHASE_ON: begin
               if (req_rpm_sample > peak_e) nx_peak = req_rpm_sample;
               // a full sample counter freezes the sum and the count
               if (count_e != '1) begin
                  nx_total = total_e + 48'(req_rpm_sample);
                  nx_count = count_e + 32'd1;
               end
               if (elapsed >= 32'(on_ms)) begin
                  nx_rec   = 1'b1;
                  nx_cycle = cyc_e + 8'd1;
                  nx_phase = PHASE_OFF;
                  nx_start = req_now_ms;
               end
            end
            PHASE_OFF: begin
               if (elapsed >= 32'(off_ms)) begin
                  if (cyc_e >= cyc_total_ff) begin
                     nx_phase = PHASE_DONE;
                     nx_done  = 1'b1;
                  end else begin
                     nx_phase = PHASE_ON;
                     nx_start = req_now_ms;
                     nx_peak  = '0;
                     nx_total = '0;
                     nx_count = '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      diff   = (res_ff.mean_rpm > res_ff.target_rpm) ?
               res_ff.mean_rpm - res_ff.target_rpm : res_ff.target_rpm - res_ff.mean_rpm;
      res_in = res_ff;
      if (cmd.step) begin
         res_in.pwm_enable   = nx_phase == PHASE_ON;
         res_in.record_valid = nx_rec;
         res_in.record_cycle = nx_rec ? nx_cycle : 8'd0;
         res_in.target_rpm   = '0;
         res_in.peak_rpm     = nx_rec ? nx_peak : 16'd0;
         res_in.mean_rpm     = '0;
         res_in.speed_error  = 1'b0;
         res_in.spun_up      = nx_rec && (nx_peak != 16'd0);
         res_in.test_done    = nx_done;
         res_in.phase_now    = 2'(nx_phase);
      end
      if (cmd.latch_tgt) begin
         res_in.target_rpm = (div_quo[DIV_DVD_W-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
      end
      if (cmd.latch_mean) begin
         res_in.mean_rpm = (count_ff == '0) ? 16'd0 : div_quo[15:0];
      end
      if (cmd.check) begin
         // floor(diff*100/target) > 20  <=>  diff*100 >= 21*target
         res_in.speed_error = (res_ff.mean_rpm == 16'd0) ||
                              ((res_ff.target_rpm != 16'd0) &&
                               (23'(diff) * 23'(PCT_SCALE) >=
                                23'(res_ff.target_rpm) * 23'(PCT_LIMIT + 1)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_sec_ff    <= 12'd10;
         off_sec_ff   <= 12'd10;
         cyc_total_ff <= 8'd10;
         freq_ff      <= 20'd1000;
         ppr_ff       <= 8'd2;
         phase_ff     <= PHASE_OFF;
         run_prev_ff  <= 1'b0;
         cycle_ff     <= '0;
         start_ms_ff  <= '0;
         peak_ff      <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         sel_ff       <= DIV_TARGET;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_ON_SECONDS:     on_sec_ff    <= csr_wdata[11:0];
               CSR_OFF_SECONDS:    off_sec_ff   <= csr_wdata[11:0];
               CSR_CYCLE_TOTAL:    cyc_total_ff <= csr_wdata[7:0];
               CSR_TEST_FREQ_HZ:   freq_ff      <= csr_wdata;
               CSR_PULSES_PER_REV: ppr_ff       <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (cmd.step) begin
            phase_ff    <= nx_phase;
            run_prev_ff <= req_run_flag;
            cycle_ff    <= nx_cycle;
            start_ms_ff <= nx_start;
            peak_ff     <= nx_peak;
            total_ff    <= nx_total;
            count_ff    <= nx_count;
         end
         if (cmd.div_start) sel_ff <= cmd.div_sel;
         if (cmd.publish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      res_ff <= res_in;
      if (cmd.publish) out_ff <= res_ff;
   end

   assign sts.record    = nx_rec;
   assign sts.div_busy  = div_busy;
   assign sts.slot_free = !out_valid_ff || rsp_ready;
   assign rsp_valid     = out_valid_ff;
   assign rsp_data      = out_ff;

endmodule

// ===== design/mct_ctrl.sv =====
// Tester controller: sequences a transaction through step, divisions and publish.
// Depends on mct_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mct_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mct_pkg::sts_type sts,
   output mct_pkg::cmd_type cmd
);
   import mct_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TGT_START,
      S_TGT_WAIT,
      S_MEAN_START,
      S_MEAN_WAIT,
      S_CHECK,
      S_FINISH
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= sts.record ? S_TGT_START : S_FINISH;
            end
            S_TGT_START:  state_ff <= S_TGT_WAIT;
            S_TGT_WAIT: begin
               if (!sts.div_busy) state_ff <= S_MEAN_START;
            end
            S_MEAN_START: state_ff <= S_MEAN_WAIT;
            S_MEAN_WAIT: begin
               if (!sts.div_busy) state_ff <= S_CHECK;
            end
            S_CHECK:      state_ff <= S_FINISH;
            S_FINISH: begin
               if (sts.slot_free) state_ff <= S_IDLE;
            end
            default:      state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      req_ready      = state_ff == S_IDLE;
      cmd.step       = req_ready && req_valid;
      cmd.div_start  = (state_ff == S_TGT_START) || (state_ff == S_MEAN_START);
      cmd.div_sel    = (state_ff == S_MEAN_START) ? DIV_MEAN : DIV_TARGET;
      cmd.latch_tgt  = (state_ff == S_TGT_WAIT) && !sts.div_busy;
      cmd.latch_mean = (state_ff == S_MEAN_WAIT) && !sts.div_busy;
      cmd.check      = state_ff == S_CHECK;
      cmd.publish    = (state_ff == S_FINISH) && sts.slot_free;
   end

   `MCT_ASSERT_NEVER(a_ready_div_idle, clock, reset, req_ready && sts.div_busy, "accept while divider busy")
   `MCT_ASSERT(a_record_to_div, clock, reset, (cmd.step && sts.record) |=> (state_ff == S_TGT_START), "record step skipped divisions")
   `MCT_ASSERT(a_busy_from_start, clock, reset, $rose(sts.div_busy) |-> $past(cmd.div_start), "divider busy without start")

endmodule

// ===== design/motor_on_off_cycle_tester_core.sv =====
// Top level of the motor on/off cycle tester: channels, controller, datapath.
// Depends on mct_pkg, mct_req_if, mct_rsp_if, mct_ctrl and mct_datapath.
//
//  Channel  Dir  Handshake           Transaction
//  -------  ---  ------------------  -----------------------------------------
//  req_ch   in   valid/ready         now_ms, run_flag, rpm_sample
//  rsp_ch   out  valid/ready         one result per request transaction
//  csr_*    in   csr_wen, no stall   csr_index selects register, csr_wdata
//
// A transaction without a record goes from the accept straight to the publish.
// A transaction that closes an ON phase runs the shared one-bit-per-cycle
// divider twice: 26 steps for the target, then 16 for the mean.
// Reset is synchronous and active high; it loads the register defaults.
// A finished result waits in the output register; a new request is still
// accepted then, and only its own publish holds until rsp_ch drains.
module motor_on_off_cycle_tester_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [mct_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mct_pkg::CSR_DATA_W-1:0]  csr_wdata,
   mct_req_if.sink                         req_ch,
   mct_rsp_if.source                       rsp_ch
);
   import mct_pkg::*;

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_data;
   logic    rsp_valid;

   // sequence each transaction; ready only between transactions
   mct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold configuration, phase state and the staged result
   mct_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .sts            (sts),
      .req_now_ms     (req_ch.now_ms),
      .req_run_flag   (req_ch.run_flag),
      .req_rpm_sample (req_ch.rpm_sample),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

   // drive the result channel from the output register
   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.pwm_enable   = rsp_data.pwm_enable;
   assign rsp_ch.record_valid = rsp_data.record_valid;
   assign rsp_ch.record_cycle = rsp_data.record_cycle;
   assign rsp_ch.target_rpm   = rsp_data.target_rpm;
   assign rsp_ch.peak_rpm     = rsp_data.peak_rpm;
   assign rsp_ch.mean_rpm     = rsp_data.mean_rpm;
   assign rsp_ch.speed_error  = rsp_data.speed_error;
   assign rsp_ch.spun_up      = rsp_data.spun_up;
   assign rsp_ch.test_done    = rsp_data.test_done;
   assign rsp_ch.phase_now    = rsp_data.phase_now;

endmodule
